// ===== design/b64e_pkg.sv =====
// Shared types, constants and alphabet lookup for the Base64 stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

	localparam int unsigned LINE_LEN_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [LINE_LEN_W-1:0] LINE_LEN_MIN   = 16'd4;
	localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 16'd76;

	localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_FEEDS_ON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 2'd2;

	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// one gathered group of 1..3 bytes, left aligned
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        last;
	} b64e_group_t;

	typedef struct packed {
		logic                  url_alphabet;
		logic                  line_feeds_on;
		logic [LINE_LEN_W-1:0] line_len;
	} b64e_cfg_t;

	function automatic logic [7:0] b64e_sym(input logic [5:0] idx, input logic url);
		logic [7:0] ch;
		if (idx < 6'd26) begin
			ch = 8'd65 + {2'b00, idx};
		end else if (idx < 6'd52) begin
			ch = 8'd71 + {2'b00, idx};
		end else if (idx < 6'd62) begin
			ch = {2'b00, idx} - 8'd4;
		end else if (idx == 6'd62) begin
			ch = url ? 8'h2D : 8'h2B;
		end else begin
			ch = url ? 8'h5F : 8'h2F;
		end
		return ch;
	endfunction

endpackage

// ===== design/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: config registers, gatherer and emitter.
// Usage:
//   Input channel (in_valid/in_stall, in_byte, is_last) takes one raw byte per
//   transfer; is_last closes the message. Output channel (out_valid/out_stall,
//   out_char, end_of_run) gives one character, '=' pad or newline per transfer;
//   end_of_run flags the last character caused by an input byte.
//   A byte that completes a group (third byte or is_last) is held in the group
//   register, from which its characters are loaded into the output register.
//   Other bytes give nothing and are taken every cycle.
//   The emitter sends one character per cycle while out_stall is low, up to five
//   per group (four plus one newline); sustained input over full groups is set by
//   the single output port. A short final group still holds the emitter for up to
//   five characters, pads and newline included.
//   in_stall rises only for a group-completing byte while the group register
//   still holds an unfinished group.
//   Out stall holds the output register; the next group waits in the group
//   register and input stalls behind it.
//   Reset clears the partial group, line offset and config to defaults
//   (standard alphabet, no line feeds, line length 76). The user must write config
//   through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module base64_stream_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [b64e_pkg::LINE_LEN_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_byte,
	input  logic                            is_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_char,
	output logic                            end_of_run
);
	import b64e_pkg::*;

	b64e_cfg_t   cfg_q;
	logic        grp_valid;
	b64e_group_t grp;
	logic        grp_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.url_alphabet  <= 1'b0;
			cfg_q.line_feeds_on <= 1'b0;
			cfg_q.line_len      <= LINE_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_URL_ALPHABET:  cfg_q.url_alphabet  <= cfg_data[0];
				CFG_LINE_FEEDS_ON: cfg_q.line_feeds_on <= cfg_data[0];
				CFG_LINE_LENGTH:   cfg_q.line_len      <= cfg_data;
				default: ;
			endcase
		end
	end

	b64e_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.is_last   (is_last),
		.grp_valid (grp_valid),
		.grp       (grp),
		.grp_take  (grp_take)
	);

	b64e_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.grp_valid  (grp_valid),
		.grp        (grp),
		.grp_take   (grp_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

`ifndef SYNTHESIS
	a_nl_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_char == CHAR_NL) |-> !end_of_run)
		else $error("newline flagged as end of run");

	a_stall_needs_grp: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> grp_valid)
		else $error("input stalled with empty group register");

	a_take_needs_grp: assert property (@(posedge clk) disable iff (!arst_n)
		grp_take |-> (grp_valid && !(out_valid && out_stall)))
		else $error("group released without emitting its last character");

	a_take_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		grp_take |=> (out_valid && end_of_run))
		else $error("group release did not produce end of run");
`endif

endmodule

// ===== design/b64e_gather.sv =====
// Byte gatherer: collects up to three input bytes and hands a group to the emitter.
`timescale 1ns / 1ps

module b64e_gather (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             in_byte,
	input  logic                   is_last,
	output logic                   grp_valid,
	output b64e_pkg::b64e_group_t  grp,
	input  logic                   grp_take
);
	import b64e_pkg::*;

	logic [15:0] held_q;
	logic [1:0]  fill_q;
	logic        grp_valid_q;
	b64e_group_t grp_q;

	logic        complete;
	logic        grp_free;
	logic        accept;
	logic [1:0]  nbytes;
	logic [23:0] bits;

	assign complete = (fill_q == 2'd2) || is_last;
	assign grp_free = !grp_valid_q || grp_take;
	assign in_stall = complete && !grp_free;
	assign accept   = in_valid && !in_stall;
	assign nbytes   = fill_q + 2'd1;

	always_comb begin
		case (fill_q)
			2'd0:    bits = {in_byte, 16'h0000};
			2'd1:    bits = {held_q[7:0], in_byte, 8'h00};
			default: bits = {held_q, in_byte};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			fill_q      <= '0;
			grp_valid_q <= 1'b0;
		end else begin
			if (grp_take) begin
				grp_valid_q <= 1'b0;
			end
			if (accept) begin
				if (complete) begin
					held_q      <= '0;
					fill_q      <= '0;
					grp_valid_q <= 1'b1;
				end else begin
					held_q <= {held_q[7:0], in_byte};
					fill_q <= nbytes;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && complete) begin
			grp_q.bits   <= bits;
			grp_q.nbytes <= nbytes;
			grp_q.last   <= is_last;
		end
	end

	assign grp_valid = grp_valid_q;
	assign grp       = grp_q;

endmodule

// ===== design/b64e_emit.sv =====
// Character emitter: one character, pad or newline per cycle into the output register unless out_stall holds it.
`timescale 1ns / 1ps

module b64e_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64e_pkg::b64e_cfg_t   cfg,
	input  logic                  grp_valid,
	input  b64e_pkg::b64e_group_t grp,
	output logic                  grp_take,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_char,
	output logic                  end_of_run
);
	import b64e_pkg::*;

	logic [1:0]            k_q;
	logic [LINE_LEN_W-1:0] offset_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  eor_q;

	logic                  out_free;
	logic                  adv;
	logic [LINE_LEN_W-1:0] len;
	logic                  need_nl;
	logic [1:0]            last_idx;
	logic                  at_last;
	logic [5:0]            sextet;
	logic [7:0]            ch;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = grp_valid && out_free;
	assign len      = (cfg.line_len < LINE_LEN_MIN) ? LINE_LEN_MIN : cfg.line_len;
	assign need_nl  = cfg.line_feeds_on && (offset_q >= len);
	assign last_idx = cfg.url_alphabet ? grp.nbytes : 2'd3;
	assign at_last  = (k_q == last_idx);

	always_comb begin
		case (k_q)
			2'd0:    sextet = grp.bits[23:18];
			2'd1:    sextet = grp.bits[17:12];
			2'd2:    sextet = grp.bits[11:6];
			default: sextet = grp.bits[5:0];
		endcase
	end

	assign ch       = (k_q <= grp.nbytes) ? b64e_sym(sextet, cfg.url_alphabet) : CHAR_PAD;
	assign grp_take = adv && !need_nl && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= adv;
			end
			if (adv) begin
				if (need_nl) begin
					offset_q <= '0;
				end else begin
					if (at_last) begin
						k_q <= '0;
					end else begin
						k_q <= k_q + 2'd1;
					end
					if (at_last && grp.last) begin
						offset_q <= '0;
					end else if (cfg.line_feeds_on) begin
						offset_q <= offset_q + 16'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= need_nl ? CHAR_NL : ch;
			eor_q      <= !need_nl && at_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign end_of_run = eor_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for base64_stream_encoder: directed table, then random messages.
`timescale 1ns / 1ps

module testbench;
	import b64e_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [15:0] a;
		logic [15:0] b;
		int          exp_n;
		logic [39:0] txt;
	} script_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eor;
	} enc_char_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [LINE_LEN_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            in_byte;
	logic                  is_last;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            out_char;
	logic                  end_of_run;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// encoder model state
	string       std_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic        enc_url;
	logic        enc_lf;
	logic [15:0] enc_len;
	logic [15:0] enc_held;
	logic [1:0]  enc_fill;
	logic [15:0] enc_off;
	logic [7:0]  burst [0:5];
	int          burst_n;

	enc_char_t   due_chars[$];
	script_row_t script[$];

	int  errors = 0;
	int  chars_seen = 0;
	int  bytes_sent = 0;
	int  msgs_closed = 0;
	int  cfg_writes = 0;
	bit  sender_calm = 0;
	bit  hold_req = 0;
	int  holds_done = 0;

	function automatic logic [7:0] sym_of(input logic [5:0] i);
		if (enc_url && i == 6'd62)
			return "-";
		if (enc_url && i == 6'd63)
			return "_";
		return std_alpha[i];
	endfunction

	function automatic void emit_symbol(input logic [7:0] c);
		logic [15:0] lim;
		if (enc_lf) begin
			lim = (enc_len < LINE_LEN_MIN) ? LINE_LEN_MIN : enc_len;
			if (enc_off >= lim) begin
				burst[burst_n] = CHAR_NL;
				burst_n++;
				enc_off = '0;
			end
			enc_off = enc_off + 16'd1;
		end
		burst[burst_n] = c;
		burst_n++;
	endfunction

	// advances the model by one byte and leaves its characters in burst
	function automatic void encode_byte(input logic [7:0] b, input logic last);
		int          fill;
		int          k;
		logic [23:0] grp;
		burst_n = 0;
		fill = enc_fill + 1;
		if (fill > 3)
			fill = 3;
		if (fill == 3 || last) begin
			grp = {enc_held, b} << (8 * (3 - fill));
			for (k = 0; k <= fill; k++)
				emit_symbol(sym_of(grp[23 - 6 * k -: 6]));
			if (!enc_url)
				for (k = fill + 1; k < 4; k++)
					emit_symbol(CHAR_PAD);
			enc_held = '0;
			enc_fill = '0;
			if (last)
				enc_off = '0;
		end else begin
			enc_held = {enc_held[7:0], b};
			enc_fill = fill[1:0];
		end
	endfunction

	function automatic void queue_burst();
		enc_char_t e;
		int        k;
		for (k = 0; k < burst_n; k++) begin
			e.ch = burst[k];
			e.eor = (k == burst_n - 1);
			due_chars.push_back(e);
		end
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		case (idx)
			CFG_URL_ALPHABET: enc_url = val[0];
			CFG_LINE_FEEDS_ON: enc_lf = val[0];
			CFG_LINE_LENGTH: enc_len = val;
			default: ;
		endcase
	endfunction

	function automatic void add_row(input row_kind_t k, input logic [15:0] a,
			input logic [15:0] b, input int n, input logic [39:0] t);
		script_row_t r;
		r.kind = k;
		r.a = a;
		r.b = b;
		r.exp_n = n;
		r.txt = t;
		script.push_back(r);
	endfunction

	function automatic logic [15:0] rand_reg_value(input logic [CFG_IDX_W-1:0] idx);
		int r;
		case (idx)
			CFG_URL_ALPHABET: return 16'($urandom_range(1));
			CFG_LINE_FEEDS_ON: return 16'($urandom_range(9) < 7);
			CFG_LINE_LENGTH: begin
				r = $urandom_range(9);
				if (r < 5)
					return 16'($urandom_range(8));
				if (r < 8)
					return 16'($urandom_range(40, 9));
				if (r == 8)
					return LINE_LEN_RESET;
				return 16'hFFFF;
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (sender_calm)
			return 0;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// returns at the edge where the byte transfers; valid is left high
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		is_last <= last;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		if (last)
			msgs_closed++;
	endtask

	task automatic wait_idle();
		while (due_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_cfg(idx, val);
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// output side: checks each transfer and drives stall
	initial begin
		enc_char_t want;
		int        stall_len;
		int        calm_len;
		int        r;
		stall_len = 0;
		calm_len = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				chars_seen++;
				if (due_chars.size() == 0) begin
					errors++;
					$display("%0t: char %h end_of_run %b with nothing expected",
						$time, out_char, end_of_run);
				end else begin
					want = due_chars.pop_front();
					if (want.ch !== out_char) begin
						errors++;
						$display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
					end
					if (want.eor !== end_of_run) begin
						errors++;
						$display("%0t: end_of_run expected %b actual %b", $time, want.eor,
							end_of_run);
					end
				end
			end
			if (stall_len == 0) begin
				if (hold_req) begin
					hold_req = 0;
					holds_done++;
					stall_len = 90;
				end else if (calm_len > 0) begin
					calm_len--;
				end else begin
					r = $urandom_range(99);
					if (r < 55)
						stall_len = 0;
					else if (r < 90)
						stall_len = $urandom_range(3, 1);
					else if (r < 97)
						stall_len = $urandom_range(25, 8);
					else
						calm_len = $urandom_range(60, 20);
				end
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				stall_len--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned n;
		n = 0;
		while (n <= CYCLE_LIMIT) begin
			@(posedge clk);
			n++;
		end
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		script_row_t row;
		enc_char_t   e;
		int          i;
		int          k;
		int          count;
		int          phase;
		int          rand_sent;
		logic [CFG_IDX_W-1:0] idx;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		is_last <= 1'b0;
		enc_url = 1'b0;
		enc_lf = 1'b0;
		enc_len = LINE_LEN_RESET;
		enc_held = '0;
		enc_fill = '0;
		enc_off = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exp_n: -1 = model only, else typed characters
		add_row(ROW_BYTE, 16'h00, 16'd1, 4, "AA==");
		add_row(ROW_BYTE, 16'hFF, 16'd1, 4, "/w==");
		add_row(ROW_BYTE, 16'hFF, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'hFF, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'hFF, 16'd1, 4, "////");
		add_row(ROW_BYTE, 16'h4D, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h61, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h6E, 16'd0, 4, "TWFu");
		add_row(ROW_BYTE, 16'h4D, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h61, 16'd1, 4, "TWE=");
		add_row(ROW_BYTE, 16'h80, 16'd0, -1, '0);
		add_row(ROW_BYTE, 16'h01, 16'd0, -1, '0);
		add_row(ROW_BYTE, 16'h7F, 16'd1, -1, '0);
		add_row(ROW_CFG, 16'(CFG_URL_ALPHABET), 16'd1, 0, '0);
		add_row(ROW_BYTE, 16'hFB, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'hFF, 16'd1, 3, "-_8");
		add_row(ROW_BYTE, 16'h00, 16'd1, 2, "AA");
		add_row(ROW_CFG, 16'(CFG_LINE_FEEDS_ON), 16'd1, 0, '0);
		add_row(ROW_CFG, 16'(CFG_LINE_LENGTH), 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h00, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h00, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h00, 16'd0, 4, "AAAA");
		add_row(ROW_BYTE, 16'hFF, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'hFF, 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'hFF, 16'd0, 5, "\n____");
		add_row(ROW_BYTE, 16'h00, 16'd1, 3, "\nAA");
		add_row(ROW_CFG, 16'(CFG_UNUSED), 16'hFFFF, 0, '0);
		add_row(ROW_CFG, 16'(CFG_LINE_LENGTH), 16'hFFFF, 0, '0);
		add_row(ROW_CFG, 16'(CFG_URL_ALPHABET), 16'd0, 0, '0);
		add_row(ROW_BYTE, 16'h3E, 16'd0, -1, '0);
		add_row(ROW_BYTE, 16'hF0, 16'd1, -1, '0);

		for (i = 0; i < script.size(); i++) begin
			row = script[i];
			if (row.kind == ROW_CFG) begin
				in_valid <= 1'b0;
				wait_idle();
				write_reg(row.a[CFG_IDX_W-1:0], row.b);
			end else begin
				send_byte(row.a[7:0], row.b[0]);
				encode_byte(row.a[7:0], row.b[0]);
				if (row.exp_n < 0) begin
					queue_burst();
				end else begin
					for (k = 0; k < row.exp_n; k++) begin
						e.ch = row.txt[8 * (row.exp_n - 1 - k) +: 8];
						e.eor = (k == row.exp_n - 1);
						due_chars.push_back(e);
					end
				end
			end
		end

		// random messages; phases end idle, some with register changes mid-message
		phase = 0;
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			in_valid <= 1'b0;
			wait_idle();
			if (phase == 0 || $urandom_range(3) != 0) begin
				count = $urandom_range(3, 1);
				for (k = 0; k < count; k++) begin
					idx = CFG_IDX_W'($urandom_range(3));
					write_reg(idx, rand_reg_value(idx));
				end
			end
			sender_calm = (phase == 2 || phase == 7) || ($urandom_range(3) == 0);
			if (phase == 2 || phase == 7) begin
				count = 48;
				hold_req = 1;
			end else begin
				count = $urandom_range(36, 8);
			end
			for (k = 0; k < count; k++) begin
				send_byte(8'($urandom), $urandom_range(5) == 0);
				encode_byte(in_byte, is_last);
				queue_burst();
				rand_sent++;
			end
			phase++;
		end
		in_valid <= 1'b0;
		wait_idle();

		$display("Covered %0d bytes in %0d closed messages over %0d phases, %0d chars checked,",
			bytes_sent, msgs_closed, phase, chars_seen);
		$display("%0d register writes, %0d long output hold-offs", cfg_writes, holds_done);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
